>>> rtl/ip_address_text_parser_defines.svh
// Assertion macros used by the checker file.
`ifndef IP_ADDRESS_TEXT_PARSER_DEFINES_SVH
`define IP_ADDRESS_TEXT_PARSER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define IATP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define IATP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/iatp_pkg.sv
// ----------------------------------------------------------------------------
// iatp_pkg
// Types and constants of the address text parser.
// ----------------------------------------------------------------------------
package iatp_pkg;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] OCTET_MAX  = 8'hff;

  typedef logic [7:0] byte_t;

  // Result request.
  typedef struct packed {
    logic        ok;
    logic [63:0] addr_part;
    logic        part_index;
    logic        last_part;
  } res_t;

  // Input request.
  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
    logic       mode;
  } req_t;

  // Hex digit decode: bit 4 set when the character is a hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, c[3:0] + 4'd9};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction
endpackage

>>> rtl/iatp_if.sv
// ----------------------------------------------------------------------------
// iatp_in_if / iatp_out_if
// Valid/ready channels of the parser.
// ----------------------------------------------------------------------------
interface iatp_in_if import iatp_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface iatp_out_if import iatp_pkg::*; ();
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/ip_address_text_parser.sv
// ----------------------------------------------------------------------------
// ip_address_text_parser
// Parses IPv4 dotted-decimal or IPv6 text, one character per request.
// ----------------------------------------------------------------------------
// Channel | Dir | Request
// in_ch   | in  | ch[8], end_of_text, mode
// out_ch  | out | ok, addr_part[64], part_index, last_part
// 1 char per unstalled cycle; 1 result per ready cycle from a 2-entry queue.
// An end-mark character waits only while earlier results still occupy the queue.
// An IPv6 string therefore yields two results, part 0 then part 1.
// Reset is synchronous and active low and clears all parse state.
module ip_address_text_parser import iatp_pkg::*; (
  input logic clk,
  input logic rst_n,
  iatp_in_if.sink    in_ch,
  iatp_out_if.source out_ch
);
  logic room, step, fin, fin_v6;
  res_t r0, r1;

  assign in_ch.ready = room || !in_ch.payload.end_of_text;
  assign step = in_ch.valid && in_ch.ready;

  iatp_core u_core (
    .clk, .rst_n, .step, .req(in_ch.payload), .fin, .fin_v6, .res0(r0), .res1(r1)
  );

  iatp_outq u_outq (
    .clk, .rst_n, .push(fin), .push_two(fin_v6), .w0(r0), .w1(r1), .room, .out_ch
  );
endmodule

>>> rtl/iatp_core.sv
// ----------------------------------------------------------------------------
// iatp_core
// Parse state: advances one character per accepted request and, on the end
// mark, produces both result words (second only used for IPv6).
// ----------------------------------------------------------------------------
module iatp_core import iatp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  req_t  req,
  output logic  fin,
  output logic  fin_v6,
  output res_t  res0,
  output res_t  res1
);
  byte_t      ab_r [16];
  logic [4:0] wpos_r, gpos_r;
  logic       gseen_r;
  logic [15:0] hacc_r;
  logic [2:0] hcnt_r;
  logic [7:0] dacc_r;
  logic       tdec_r;
  logic [2:0] ocnt_r;
  logic       dig_r, v4t_r, pcol_r, lcol_r, cnz_r, tfin_r, err_r, fam_r;

  byte_t      ab_n [16];
  logic [4:0] wpos_n, gpos_n;
  logic       gseen_n;
  logic [15:0] hacc_n;
  logic [2:0] hcnt_n;
  logic [7:0] dacc_n;
  logic       tdec_n;
  logic [2:0] ocnt_n;
  logic       dig_n, v4t_n, pcol_n, lcol_n, tfin_n, err_n, fam_n;
  logic       first;
  logic [4:0] hd;
  logic [11:0] dv;
  logic [3:0] base;
  logic [5:0] fpos;
  byte_t      fb [16];
  byte_t      fc [16];
  logic [4:0] nmove;
  logic       ferr;
  logic [7:0] d;

  assign fin = step && req.end_of_text;
  assign fin_v6 = fam_n;

  // Per-character update.
  always_comb begin
    for (int i = 0; i < 16; i++) ab_n[i] = ab_r[i];
    wpos_n = wpos_r; gpos_n = gpos_r; gseen_n = gseen_r; hacc_n = hacc_r;
    hcnt_n = hcnt_r; dacc_n = dacc_r; tdec_n = tdec_r; ocnt_n = ocnt_r;
    dig_n = dig_r; v4t_n = v4t_r; pcol_n = pcol_r; lcol_n = lcol_r;
    tfin_n = tfin_r; err_n = err_r; fam_n = fam_r;
    first = !cnz_r;
    if (first) fam_n = req.mode;
    hd = hex_decode(req.ch);
    d = req.ch - 8'h30;
    dv = {4'd0, dacc_r} * 12'd10 + {8'd0, hd[3:0]};
    base = v4t_r ? wpos_r[3:0] : 4'd0;
    if (!tfin_r && !err_r) begin
      if (req.ch == CH_NUL) begin
        tfin_n = 1'b1;
      end else if (!fam_n || v4t_r) begin
        if (req.ch >= 8'h30 && req.ch <= 8'h39) begin
          if (!dig_r && ocnt_r >= 3'd4) err_n = 1'b1;
          else begin
            if (!dig_r) begin
              ocnt_n = ocnt_r + 3'd1;
              dig_n = 1'b1;
            end
            dv = {4'd0, dacc_r} * 12'd10 + {4'd0, d};
            if (dv > 12'd255) err_n = 1'b1;
            else dacc_n = dv[7:0];
          end
        end else if (req.ch == CH_DOT && dig_r) begin
          if (ocnt_r >= 3'd4) err_n = 1'b1;
          else begin
            ab_n[base + {1'b0, ocnt_r} - 4'd1] = dacc_r;
            dacc_n = 8'd0;
            dig_n = 1'b0;
          end
        end else err_n = 1'b1;
      end else if (first && req.ch == CH_COLON) begin
        lcol_n = 1'b1;
      end else if (lcol_r && req.ch != CH_COLON) begin
        err_n = 1'b1;
      end else begin
        lcol_n = 1'b0;
        pcol_n = 1'b0;
        if (req.ch == CH_PERCENT) tfin_n = 1'b1;
        else if (hd[4]) begin
          hacc_n = {hacc_r[11:0], hd[3:0]};
          if (hcnt_r < 3'd5) hcnt_n = hcnt_r + 3'd1;
          if (hd[3:0] > 4'd9) tdec_n = 1'b0;
          else if (tdec_r) begin
            if (dv > 12'd255) tdec_n = 1'b0;
            else dacc_n = dv[7:0];
          end
        end else if (req.ch == CH_COLON) begin
          if (hcnt_r == 3'd0) begin
            if (gseen_r) err_n = 1'b1;
            else begin
              gseen_n = 1'b1;
              gpos_n = wpos_r;
            end
          end else begin
            if (hcnt_r > 3'd4 || wpos_r > 5'd14) err_n = 1'b1;
            else begin
              ab_n[wpos_r[3:0]] = hacc_r[15:8];
              ab_n[wpos_r[3:0] + 4'd1] = hacc_r[7:0];
              wpos_n = wpos_r + 5'd2;
              pcol_n = 1'b1;
            end
          end
          if (!err_n) begin
            hacc_n = 16'd0; hcnt_n = 3'd0; dacc_n = 8'd0; tdec_n = 1'b1;
          end
        end else if (req.ch == CH_DOT && hcnt_r != 3'd0 && tdec_r && wpos_r <= 5'd12) begin
          ab_n[wpos_r[3:0]] = dacc_r;
          ocnt_n = 3'd1; dig_n = 1'b0; dacc_n = 8'd0;
          hacc_n = 16'd0; hcnt_n = 3'd0; v4t_n = 1'b1;
        end else err_n = 1'b1;
      end
    end
  end

  // End-of-text finish: store the last octet or close the last group, and expand the gap.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      fb[i] = ab_n[i];
      fc[i] = ab_n[i];
    end
    ferr = err_n;
    fpos = {1'b0, wpos_n};
    nmove = 5'd0;
    if (!fam_n) begin
      if (!ferr && (ocnt_n != 3'd4 || !dig_n)) ferr = 1'b1;
      fb[3] = dacc_n;
    end else begin
      if (lcol_n || pcol_n) ferr = 1'b1;
      if (!ferr) begin
        if (v4t_n) begin
          if (ocnt_n != 3'd4 || !dig_n) ferr = 1'b1;
          else begin
            fb[wpos_n[3:0] + 4'd3] = dacc_n;
            fpos = {1'b0, wpos_n} + 6'd4;
          end
        end else if (hcnt_n != 3'd0) begin
          if (hcnt_n > 3'd4 || wpos_n > 5'd14) ferr = 1'b1;
          else begin
            fb[wpos_n[3:0]] = hacc_n[15:8];
            fb[wpos_n[3:0] + 4'd1] = hacc_n[7:0];
            fpos = {1'b0, wpos_n} + 6'd2;
          end
        end
      end
      if (!ferr && gseen_n) begin
        if (fpos >= 6'd16 || {1'b0, gpos_n} > fpos) ferr = 1'b1;
        else begin
          // Groups after the gap slide to the top; the gap fills with zeros.
          nmove = fpos[4:0] - gpos_n;
          for (int i = 0; i < 16; i++) fc[i] = fb[i];
          for (int i = 0; i < 16; i++) begin
            if (i >= 16 - int'(nmove))
              fb[i] = fc[4'(i) + fpos[3:0]];
            else if (i >= int'(gpos_n)) fb[i] = 8'd0;
          end
          fpos = 6'd16;
        end
      end
      if (!ferr && fpos != 6'd16) ferr = 1'b1;
    end
  end

  // Result words.
  always_comb begin
    res0.ok = !ferr;
    res0.part_index = 1'b0;
    res0.last_part = !fam_n;
    res1.ok = !ferr;
    res1.part_index = 1'b1;
    res1.last_part = 1'b1;
    if (!fam_n)
      res0.addr_part = ferr ? 64'd0 : {32'd0, fb[0], fb[1], fb[2], fb[3]};
    else
      res0.addr_part = ferr ? 64'd0 : {fb[0], fb[1], fb[2], fb[3],
                                       fb[4], fb[5], fb[6], fb[7]};
    res1.addr_part = ferr ? 64'd0 : {fb[8], fb[9], fb[10], fb[11],
                                     fb[12], fb[13], fb[14], fb[15]};
  end

  // State registers; cleared on reset and after each end mark.
  always_ff @(posedge clk) begin
    if (!rst_n || fin) begin
      for (int i = 0; i < 16; i++) ab_r[i] <= 8'd0;
      wpos_r <= '0; gpos_r <= '0; gseen_r <= 1'b0; hacc_r <= '0; hcnt_r <= '0;
      dacc_r <= '0; tdec_r <= 1'b1; ocnt_r <= '0; dig_r <= 1'b0; v4t_r <= 1'b0;
      pcol_r <= 1'b0; lcol_r <= 1'b0; cnz_r <= 1'b0; tfin_r <= 1'b0;
      err_r <= 1'b0; fam_r <= 1'b0;
    end else if (step) begin
      for (int i = 0; i < 16; i++) ab_r[i] <= ab_n[i];
      wpos_r <= wpos_n; gpos_r <= gpos_n; gseen_r <= gseen_n; hacc_r <= hacc_n;
      hcnt_r <= hcnt_n; dacc_r <= dacc_n; tdec_r <= tdec_n; ocnt_r <= ocnt_n;
      dig_r <= dig_n; v4t_r <= v4t_n; pcol_r <= pcol_n; lcol_r <= lcol_n;
      cnz_r <= 1'b1; tfin_r <= tfin_n; err_r <= err_n; fam_r <= fam_n;
    end
  end
endmodule

>>> rtl/iatp_outq.sv
// ----------------------------------------------------------------------------
// iatp_outq
// Two-entry result queue feeding the output channel.
// ----------------------------------------------------------------------------
module iatp_outq import iatp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic push_two,
  input  res_t w0,
  input  res_t w1,
  output logic room,
  iatp_out_if.source out_ch
);
  res_t q_r [2];
  logic [1:0] cnt_r;
  logic pop;

  assign pop = out_ch.valid && out_ch.ready;
  assign out_ch.valid = cnt_r != 2'd0;
  assign out_ch.payload = q_r[0];
  // Room for a full string result once the head drains this cycle.
  assign room = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else if (push) cnt_r <= push_two ? 2'd2 : 2'd1;
    else if (pop) cnt_r <= cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[0] <= w0;
      q_r[1] <= w1;
    end else if (pop) q_r[0] <= q_r[1];
  end
endmodule

>>> rtl/iatp_checker.sv
// ----------------------------------------------------------------------------
// iatp_checker
// Port-level checks of the parser's result stream.
// ----------------------------------------------------------------------------
`include "ip_address_text_parser_defines.svh"
module iatp_checker import iatp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input res_t out_payload
);
  `IATP_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && !out_payload.ok, out_payload.addr_part == 64'd0)
  `IATP_ASSERT_IMP(a_p1_last, clk, rst_n, out_valid && out_payload.part_index, out_payload.last_part)
  `IATP_ASSERT_NXT(a_p0_follow, clk, rst_n, out_valid && out_ready && !out_payload.last_part, out_valid && out_payload.part_index)
  `IATP_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload))
endmodule

bind ip_address_text_parser iatp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_payload(out_ch.payload)
);
